// ===== hw/rtl/mrr_pkg.sv =====
// package for the miller-rabin round block: payload types, sizes, sequencer states
// no dependencies
`timescale 1ns / 1ps
package mrr_pkg;

    localparam int unsigned WIDTH_DEFAULT = 64;
    localparam int unsigned FIELD_W       = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] witness;
    } mrr_in_t;

    typedef struct packed {
        logic probable_prime;
        logic decided_trivially;
    } mrr_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_WAIT,
        ST_SPLIT,
        ST_POW_MUL,
        ST_POW_MUL_WAIT,
        ST_POW_SQR,
        ST_POW_SQR_WAIT,
        ST_CHECK,
        ST_SQR,
        ST_SQR_WAIT,
        ST_DONE
    } mrr_state_t;

endpackage

// ===== hw/rtl/mrr_mulmod.sv =====
// bit-serial modular multiplier: acc = x * y mod m, one multiplier bit per cycle
// depends on mrr_pkg (no types used beyond widths handed in)
`timescale 1ns / 1ps
module mrr_mulmod
    import mrr_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic [WIDTH-1:0] result
);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] xs_reg, xs_next;
    logic [WIDTH-1:0] ys_reg, ys_next;
    logic             busy_reg, busy_next;
    logic [WIDTH:0]   acc_sum, dbl_sum;
    logic [WIDTH-1:0] acc_red, dbl_red;

    // exact wide sums, one subtract of the modulus where needed
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + {1'b0, xs_reg};
        acc_red = (acc_sum >= {1'b0, m}) ? WIDTH'(acc_sum - {1'b0, m}) : acc_sum[WIDTH-1:0];
        dbl_sum = {xs_reg, 1'b0};
        dbl_red = (dbl_sum >= {1'b0, m}) ? WIDTH'(dbl_sum - {1'b0, m}) : dbl_sum[WIDTH-1:0];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            xs_next   = x;
            ys_next   = y;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ys_reg == '0)
                busy_next = 1'b0;
            else
            begin
                if (ys_reg[0])
                    acc_next = acc_red;
                xs_next = dbl_red;
                ys_next = ys_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        xs_reg  <= xs_next;
        ys_reg  <= ys_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ===== hw/rtl/mrr_reduce.sv =====
// bit-serial remainder: r = a mod m by restoring shift-subtract, one bit per cycle
// depends on mrr_pkg for the default width
`timescale 1ns / 1ps
module mrr_reduce
    import mrr_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic [WIDTH-1:0] result
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsh_reg, dsh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, dsh_reg[WIDTH-1]};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            dsh_next  = a;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
            begin
                rem_next = (trial >= {1'b0, m}) ? WIDTH'(trial - {1'b0, m})
                                                : trial[WIDTH-1:0];
                dsh_next = dsh_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
    end

    assign busy   = busy_reg;
    assign result = rem_reg;

endmodule

// ===== hw/rtl/miller_rabin_round_64.sv =====
// One strong-probable-prime round per item: a candidate n and a witness a go in,
// probable_prime and decided_trivially come out. Trivial candidates (below 2, 2, 3,
// even) go from acceptance straight to ST_DONE and on into the output register.
// Otherwise the witness is first reduced mod n, n-1 is split into d*2^s one bit per
// cycle, then a^d mod n is formed by square-and-multiply and up to s-1 squarings
// follow. Every modular product goes through one shared bit-serial multiplier.
// One item at a time; the result waits in an output register while the next item
// is already taken.
// depends on mrr_pkg, mrr_mulmod, mrr_reduce
`timescale 1ns / 1ps
module miller_rabin_round_64
    import mrr_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mrr_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output mrr_out_t out_data
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    mrr_state_t state_reg, state_next;

    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] e_reg, e_next;      // exponent shifted out one bit per step
    logic [WIDTH-1:0] x_reg, x_next;      // accumulator of the power
    logic [CNT_W-1:0] s_reg, s_next;
    logic             first_reg, first_next;  // no squaring done yet
    mrr_out_t         res_reg, res_next;
    logic             ovalid_reg, ovalid_next;
    mrr_out_t         odata_reg, odata_next;

    logic             mul_start, red_start;
    logic [WIDTH-1:0] mul_x, mul_y;
    logic             mul_busy, red_busy;
    logic [WIDTH-1:0] mul_res, red_res;

    logic [WIDTH-1:0] cand, wit, nm1;
    logic             busy_item;
    logic             pass_now;

    assign cand = in_data.candidate[WIDTH-1:0];
    assign wit  = in_data.witness[WIDTH-1:0];
    assign nm1  = n_reg - 1'b1;

    // x = 1 only counts before any squaring
    assign pass_now = (first_reg && x_reg == WIDTH'(1)) || x_reg == nm1;

    mrr_mulmod #(.WIDTH(WIDTH)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (n_reg),
        .busy   (mul_busy),
        .result (mul_res)
    );

    mrr_reduce #(.WIDTH(WIDTH)) u_red (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (red_start),
        .a      (a_reg),
        .m      (n_reg),
        .busy   (red_busy),
        .result (red_res)
    );

    assign busy_item = (state_reg != ST_IDLE);
    assign in_ready  = !busy_item;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = (cand < WIDTH'(4) || !cand[0]) ? ST_DONE : ST_RED_START;
            ST_RED_START:    state_next = ST_RED_WAIT;
            ST_RED_WAIT:     if (!red_busy) state_next = ST_SPLIT;
            ST_SPLIT:        if (e_reg[0]) state_next = ST_POW_MUL;
            ST_POW_MUL:      state_next = ST_POW_MUL_WAIT;
            ST_POW_MUL_WAIT: if (!mul_busy) state_next = ST_POW_SQR;
            ST_POW_SQR:      state_next = (e_reg == '0) ? ST_CHECK : ST_POW_SQR_WAIT;
            ST_POW_SQR_WAIT: if (!mul_busy) state_next = ST_POW_MUL;
            ST_CHECK:
                if (pass_now || s_reg <= CNT_W'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_SQR;
            ST_SQR:          state_next = ST_SQR_WAIT;
            ST_SQR_WAIT:     if (!mul_busy) state_next = ST_CHECK;
            ST_DONE:
                if (!ovalid_reg || out_ready)
                    state_next = ST_IDLE;
            default:         state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next      = n_reg;
        a_next      = a_reg;
        e_next      = e_reg;
        x_next      = x_reg;
        s_next      = s_reg;
        first_next  = first_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        mul_start   = 1'b0;
        red_start   = 1'b0;
        mul_x       = x_reg;
        mul_y       = x_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                begin
                    n_next = cand;
                    a_next = wit;
                    res_next.decided_trivially = 1'b1;
                    res_next.probable_prime    = (cand == WIDTH'(2) || cand == WIDTH'(3));
                end
            ST_RED_START:
            begin
                red_start  = 1'b1;
                e_next     = nm1;
                s_next     = '0;
                x_next     = WIDTH'(1);
                first_next = 1'b1;
            end
            ST_RED_WAIT:
                if (!red_busy)
                    a_next = red_res;
            ST_SPLIT:
                if (!e_reg[0])
                begin
                    e_next = e_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            ST_POW_MUL:
            begin
                // multiply only when the current exponent bit is set
                if (e_reg[0])
                begin
                    mul_start = 1'b1;
                    mul_x     = x_reg;
                    mul_y     = a_reg;
                end
            end
            ST_POW_MUL_WAIT:
                if (!mul_busy && e_reg[0])
                    x_next = mul_res;
            ST_POW_SQR:
            begin
                e_next = e_reg >> 1;
                if ((e_reg >> 1) != '0)
                begin
                    mul_start = 1'b1;
                    mul_x     = a_reg;
                    mul_y     = a_reg;
                end
            end
            ST_POW_SQR_WAIT:
                if (!mul_busy)
                    a_next = mul_res;
            ST_CHECK:
                if (pass_now || s_reg <= CNT_W'(1))
                begin
                    res_next.decided_trivially = 1'b0;
                    res_next.probable_prime    = pass_now;
                end
            ST_SQR:
            begin
                mul_start  = 1'b1;
                mul_x      = x_reg;
                mul_y      = x_reg;
                s_next     = s_reg - 1'b1;
                first_next = 1'b0;
            end
            ST_SQR_WAIT:
                if (!mul_busy)
                    x_next = mul_res;
            ST_DONE:
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        a_reg     <= a_next;
        e_reg     <= e_next;
        x_reg     <= x_next;
        s_reg     <= s_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== hw/rtl/mrr_checker.sv =====
// port-level checker for miller_rabin_round_64, attached by bind
// depends on mrr_pkg
`timescale 1ns / 1ps
module mrr_checker
    import mrr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input mrr_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input mrr_out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one item at a time: no new item right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input item changed while waiting");

    // no result can appear the cycle after an item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind miller_rabin_round_64 mrr_checker u_mrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/tb.sv =====
// testbench for miller_rabin_round_64: directed and random strong-probable-prime rounds
// checked against an in-bench predictor; depends on mrr_pkg and the block rtl
`timescale 1ns / 1ps
module tb;
    import mrr_pkg::*;

    localparam int unsigned WIDTH = 64;
    localparam int unsigned WATCHDOG_LIMIT = 200000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mrr_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mrr_out_t out_data;

    mrr_out_t   verdict_q[$];
    int         errors;
    int         idle_cycles;
    int         stall_cnt;
    logic       drain_stall;

    miller_rabin_round_64 #(.WIDTH(WIDTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact modular add using a 65-bit sum
    function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[63:0];
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        x = x % m;
        y = y % m;
        while (y != 0)
        begin
            if (y[0])
                acc = add_mod(acc, x, m);
            x = add_mod(x, x, m);
            y = y >> 1;
        end
        return acc;
    endfunction

    function automatic mrr_out_t predict_round(mrr_in_t item);
        mrr_out_t    res;
        logic [63:0] n, a, d, x, nm1, b, e;
        int          s;
        logic        pass;
        n = item.candidate;
        a = item.witness;
        res = '0;
        if (n < 2)
        begin
            res.decided_trivially = 1'b1;
            return res;
        end
        if (n == 2 || n == 3)
        begin
            res.probable_prime = 1'b1;
            res.decided_trivially = 1'b1;
            return res;
        end
        if (!n[0])
        begin
            res.decided_trivially = 1'b1;
            return res;
        end
        nm1 = n - 1;
        d = nm1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        x = 64'd1;
        b = a % n;
        e = d;
        while (e != 0)
        begin
            if (e[0])
                x = mul_mod(x, b, n);
            b = mul_mod(b, b, n);
            e = e >> 1;
        end
        pass = (x == 1 || x == nm1);
        for (int r = 1; !pass && r < s; r++)
        begin
            x = mul_mod(x, x, n);
            if (x == nm1)
                pass = 1'b1;
        end
        res.probable_prime = pass;
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_item(logic [63:0] cand, logic [63:0] wit);
        mrr_in_t item;
        int      gap;
        item.candidate = cand;
        item.witness = wit;
        gap = gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(predict_round(item));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // random odd value of the given bit length, top bit set
    function automatic logic [63:0] rand_odd(int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64)
            v = v & ((64'd1 << bits) - 1);
        v[bits-1] = 1'b1;
        v[0] = 1'b1;
        return v;
    endfunction

    task automatic test_trivial();
        send_item(64'd0, 64'd5);
        send_item(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd2, 64'd0);
        send_item(64'd3, 64'd2);
        send_item(64'd4, 64'd2);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 64'd3);
    endtask

    task automatic test_known_values();
        send_item(64'd5, 64'd2);
        send_item(64'd561, 64'd2);                        // carmichael
        send_item(64'd2047, 64'd2);                       // strong pseudoprime base 2
        send_item(64'd2047, 64'd3);
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);        // largest 64-bit prime
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC3);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(64'h8000_0000_0000_0001, 64'hAAAA_5555_AAAA_5555);
    endtask

    task automatic test_odd_witness();
        // witness congruent to 0, 1, n-1, and above n
        send_item(64'd97, 64'd0);
        send_item(64'd97, 64'd97);
        send_item(64'd97, 64'd1);
        send_item(64'd97, 64'd96);
        send_item(64'd97, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd7, 64'd6);
    endtask

    task automatic test_random();
        logic [63:0] cand;
        logic [63:0] wit;
        int          sel;
        for (int i = 0; i < 100; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                cand = {$urandom, $urandom};
            else if (sel < 4)
                cand = rand_odd($urandom_range(3, 20));
            else
                cand = rand_odd($urandom_range(21, 64));
            if ($urandom_range(0, 7) == 0)
                wit = {$urandom, $urandom};
            else if (cand > 4)
                wit = 64'd2 + ({$urandom, $urandom} % (cand - 3));
            else
                wit = $urandom;
            send_item(cand, wit);
            if (i == 50)
                wait_drained();
        end
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result %b", $time, out_data);
                errors++;
            end
            else
            begin
                mrr_out_t exp_v;
                exp_v = verdict_q.pop_front();
                if (out_data.probable_prime !== exp_v.probable_prime)
                begin
                    $display("%0t: probable_prime expected %b actual %b", $time,
                             exp_v.probable_prime, out_data.probable_prime);
                    errors++;
                end
                if (out_data.decided_trivially !== exp_v.decided_trivially)
                begin
                    $display("%0t: decided_trivially expected %b actual %b", $time,
                             exp_v.decided_trivially, out_data.decided_trivially);
                    errors++;
                end
            end
        end
        if (!drain_stall)
            out_ready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            out_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            // occasional long stall
            out_ready <= 1'b0;
            stall_cnt <= $urandom_range(5, 40);
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        stall_cnt = 0;
        drain_stall = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_trivial();
        test_known_values();
        test_odd_witness();
        test_random();
        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
